@@ design/smcf_pkg.sv @@
// shared types and constants of the stepper move command framer
// frame layout, byte positions, direction codes and queue sizing; no dependencies
package smcf_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int NUM_GUIDES = 2;

	localparam int POS_W   = 32;
	localparam int MOVE_W  = POS_W + 1;
	localparam int PPM_W   = 16;
	localparam int PROD_W  = MOVE_W + PPM_W;
	localparam int PULSE_W = 24;
	localparam int GUIDE_W = 2;

	localparam int FRAME_LEN = 10;
	localparam int BYTE_W    = $clog2(FRAME_LEN);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [PPM_W-1:0] PPM_RESET = 16'd320;

	localparam logic [7:0] SYNC0    = 8'hFF;
	localparam logic [7:0] SYNC1    = 8'hAA;
	localparam logic [7:0] PAD      = 8'h00;
	localparam logic [7:0] DIR_UP   = 8'h2F;
	localparam logic [7:0] DIR_DOWN = 8'h1F;

	// byte positions inside one frame
	localparam logic [BYTE_W-1:0] BP_SYNC0 = BYTE_W'(0);
	localparam logic [BYTE_W-1:0] BP_SYNC1 = BYTE_W'(1);
	localparam logic [BYTE_W-1:0] BP_ZERO  = BYTE_W'(2);
	localparam logic [BYTE_W-1:0] BP_ID    = BYTE_W'(3);
	localparam logic [BYTE_W-1:0] BP_DIR   = BYTE_W'(4);
	localparam logic [BYTE_W-1:0] BP_P0    = BYTE_W'(5);
	localparam logic [BYTE_W-1:0] BP_P1    = BYTE_W'(6);
	localparam logic [BYTE_W-1:0] BP_P2    = BYTE_W'(7);
	localparam logic [BYTE_W-1:0] BP_PAD   = BYTE_W'(8);
	localparam logic [BYTE_W-1:0] BP_SUM   = BYTE_W'(FRAME_LEN - 1);

	localparam logic [GUIDE_W-1:0] FIRST_GUIDE = GUIDE_W'(1);
	localparam logic [GUIDE_W-1:0] LAST_GUIDE  = GUIDE_W'(NUM_GUIDES);

	typedef struct packed {
		logic [PULSE_W-1:0] pulse;
		logic               positive;
	} move_cmd_t;

endpackage

@@ design/smcf_front.sv @@
// front end: takes target positions, forms move magnitude and pulse count
// two pipeline stages feeding the command queue; uses smcf_pkg
module smcf_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [smcf_pkg::POS_W-1:0] target_position,
	input  logic [smcf_pkg::PPM_W-1:0] pulses_per_mm,
	output logic                       q_push,
	input  logic                       q_full,
	output smcf_pkg::move_cmd_t        q_data
);
	import smcf_pkg::*;

	logic [POS_W-1:0]  prev_target_q;
	logic              v_s1;
	logic [MOVE_W-1:0] mag_s1;
	logic              pos_s1;
	logic              v_s2;
	logic [PULSE_W-1:0] pulse_s2;
	logic              pos_s2;

	logic signed [MOVE_W-1:0] move;
	logic [MOVE_W-1:0] mag;
	logic [PROD_W-1:0] prod;
	logic rdy1, rdy2;

	assign move = MOVE_W'($signed(target_position)) - MOVE_W'($signed(prev_target_q));
	assign mag  = move[MOVE_W-1] ? MOVE_W'(-move) : MOVE_W'(move);
	assign prod = PROD_W'(mag_s1) * PROD_W'(pulses_per_mm);

	assign rdy2     = !v_s2 || !q_full;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;
	assign q_push   = v_s2 && !q_full;
	assign q_data   = '{pulse: pulse_s2, positive: pos_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_target_q <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
				if (in_valid) begin
					prev_target_q <= target_position;
				end
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			mag_s1 <= mag;
			pos_s1 <= !move[MOVE_W-1] && (move != '0);
		end
		if (rdy2 && v_s1) begin
			pulse_s2 <= prod[FRAC_BITS +: PULSE_W];
			pos_s2   <= pos_s1;
		end
	end

endmodule

@@ design/smcf_queue.sv @@
// short command queue between front and back ends
// register file with read and write pointers; uses smcf_pkg
module smcf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  smcf_pkg::move_cmd_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output smcf_pkg::move_cmd_t head
);
	import smcf_pkg::*;

	move_cmd_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
	endfunction

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= QCNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= QCNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ design/smcf_back.sv @@
// back end: serialises one queued command into the framed byte run
// byte and guide counters with a registered output; uses smcf_pkg
module smcf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  smcf_pkg::move_cmd_t          q_head,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   tx_byte,
	output logic [smcf_pkg::GUIDE_W-1:0] guide_id,
	output logic                         last_byte
);
	import smcf_pkg::*;

	localparam logic [7:0] HDR_SUM = SYNC0 + SYNC1;

	move_cmd_t          cur_q;
	logic               active_q;
	logic [BYTE_W-1:0]  idx_q;
	logic [GUIDE_W-1:0] guide_q;

	logic               out_valid_q;
	logic [7:0]         tx_byte_q;
	logic [GUIDE_W-1:0] guide_id_q;
	logic               last_byte_q;

	logic       load, emit, run_end, frame_end, up;
	logic [7:0] dir_code, id_byte, checksum, cur_byte;

	assign load      = !out_valid_q || !out_stall;
	assign emit      = active_q && load;
	assign frame_end = (idx_q == BP_SUM);
	assign run_end   = frame_end && (guide_q == LAST_GUIDE);
	assign q_pop     = !q_empty && (!active_q || (emit && run_end));

	assign up       = (guide_q == FIRST_GUIDE) ? cur_q.positive : !cur_q.positive;
	assign dir_code = up ? DIR_UP : DIR_DOWN;
	assign id_byte  = 8'(guide_q);
	assign checksum = HDR_SUM + id_byte + dir_code + cur_q.pulse[7:0]
		+ cur_q.pulse[15:8] + cur_q.pulse[23:16];

	always_comb begin
		unique case (idx_q)
			BP_SYNC0: cur_byte = SYNC0;
			BP_SYNC1: cur_byte = SYNC1;
			BP_ZERO:  cur_byte = PAD;
			BP_ID:    cur_byte = id_byte;
			BP_DIR:   cur_byte = dir_code;
			BP_P0:    cur_byte = cur_q.pulse[7:0];
			BP_P1:    cur_byte = cur_q.pulse[15:8];
			BP_P2:    cur_byte = cur_q.pulse[23:16];
			BP_PAD:   cur_byte = PAD;
			BP_SUM:   cur_byte = checksum;
			default:  cur_byte = PAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			guide_q     <= FIRST_GUIDE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= active_q;
			end
			if (q_pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
				guide_q  <= FIRST_GUIDE;
			end else if (emit) begin
				if (run_end) begin
					active_q <= 1'b0;
				end else if (frame_end) begin
					idx_q   <= '0;
					guide_q <= GUIDE_W'(guide_q + 1'b1);
				end else begin
					idx_q <= BYTE_W'(idx_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (emit) begin
			tx_byte_q   <= cur_byte;
			guide_id_q  <= guide_q;
			last_byte_q <= run_end;
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte   = tx_byte_q;
	assign guide_id  = guide_id_q;
	assign last_byte = last_byte_q;

endmodule

@@ design/stepper_move_command_framer_top.sv @@
// top level of the stepper move command framer
// holds the scale register and joins smcf_front, smcf_queue and smcf_back; uses smcf_pkg
//
// usage
// - input channel (in_valid / in_stall): one transfer carries a new target
//   position, signed q16.16 millimetres; the previous target is kept inside
// - output channel (out_valid / out_stall): each accepted target yields a run
//   of twenty byte transfers, a ten-byte frame for guide 1 then one for guide 2;
//   last_byte marks the closing byte of the run
// - scale port (cfg_valid / cfg_ready / cfg_data): writes pulses per millimetre,
//   always ready, meant to be written while the block is idle
// first-byte path: from an input transfer to the first byte on the output, a target runs
//   through the two-stage front (move magnitude, then the 33x16 multiply), the
//   queue write, the command load of the back end and its output register
// throughput: one byte per cycle while the receiver does not stall, set by the
//   byte serialiser of the back end; the front keeps accepting targets until
//   the four-entry queue and its two stages are full
// reset: previous target goes to zero, scale to 320, queue and counters empty
// receiver stall: the output register holds its byte, the serialiser waits,
//   and the input stalls only once the queue has filled up behind it
module stepper_move_command_framer_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [smcf_pkg::POS_W-1:0]   target_position,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   tx_byte,
	output logic [smcf_pkg::GUIDE_W-1:0] guide_id,
	output logic                         last_byte,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [smcf_pkg::PPM_W-1:0]   cfg_data
);
	import smcf_pkg::*;

	logic [PPM_W-1:0] pulses_per_mm_q;

	// queue hookup
	logic      q_push, q_full, q_pop, q_empty;
	move_cmd_t q_wdata, q_head;

	// scale register, never back-pressures
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulses_per_mm_q <= PPM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pulses_per_mm_q <= cfg_data;
		end
	end

	// front: move and pulse count
	smcf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.target_position (target_position),
		.pulses_per_mm   (pulses_per_mm_q),
		.q_push          (q_push),
		.q_full          (q_full),
		.q_data          (q_wdata)
	);

	// decoupling queue
	smcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	// back: frame serialiser
	smcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_byte   (tx_byte),
		.guide_id  (guide_id),
		.last_byte (last_byte)
	);

`ifndef SYNTHESIS
	// the run always closes on the last guide's frame
	a_last_on_last_guide: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |-> guide_id == LAST_GUIDE)
		else $error("last byte flagged outside the last guide's frame");

	// queue never written while full, nor read while empty
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full) && !(q_pop && q_empty))
		else $error("command queue overflow or underflow");

	// a run that has closed is followed by the opening sync byte of a new one
	a_run_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_byte |=> !out_valid || tx_byte == SYNC0)
		else $error("new run does not open with the sync byte");

	// the guide moves on from the first guide only onto the sync byte that opens the next frame
	a_frame_guide_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_byte && guide_id == FIRST_GUIDE
		|=> !out_valid || guide_id == FIRST_GUIDE || tx_byte == SYNC0)
		else $error("guide changed in the middle of a frame");
`endif

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for stepper_move_command_framer_top
// predicts the twenty frame bytes of every move and checks each output transfer in order
// depends on smcf_pkg and the design sources only
module tb;
	import smcf_pkg::*;

	// cycles the receiver holds off in the fill-up scenario
	localparam int LONG_HOLD     = 300;
	localparam int DIRECTED_ROWS = 19;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 60;
	localparam int REPORT_LIMIT  = 10;

	logic               clk             = 1'b0;
	logic               arst_n          = 1'b0;
	logic               in_valid        = 1'b0;
	logic               in_stall;
	logic [POS_W-1:0]   target_position = '0;
	logic               out_valid;
	logic               out_stall       = 1'b0;
	logic [7:0]         tx_byte;
	logic [GUIDE_W-1:0] guide_id;
	logic               last_byte;
	logic               cfg_valid       = 1'b0;
	logic               cfg_ready;
	logic [PPM_W-1:0]   cfg_data        = '0;

	// one frame byte as it should leave the block
	typedef struct packed {
		logic [7:0]         value;
		logic [GUIDE_W-1:0] guide;
		logic               last;
	} frame_byte_t;

	// one row of the directed table: an optional scale write before the move,
	// and for the rows that are obvious by hand the pulse count and guide 1 direction
	typedef struct packed {
		logic [POS_W-1:0]   target;
		logic               set_ppm;
		logic [PPM_W-1:0]   new_ppm;
		logic               typed;
		logic [PULSE_W-1:0] pulse;
		logic               up;
	} move_row_t;

	move_row_t directed_rows [DIRECTED_ROWS] = '{
		// zero move straight after reset, default scale of 320
		'{32'h0000_0000, 1'b0, 16'd0,     1'b1, 24'h000000, 1'b0},
		// one millimetre forward gives 320 pulses
		'{32'h0001_0000, 1'b0, 16'd0,     1'b1, 24'h000140, 1'b1},
		'{32'h0001_0000, 1'b0, 16'd0,     1'b1, 24'h000000, 1'b0},
		'{32'h0000_0000, 1'b0, 16'd0,     1'b1, 24'h000140, 1'b0},
		'{32'h7FFF_FFFF, 1'b0, 16'd0,     1'b1, 24'h9FFFFF, 1'b1},
		// full-span moves, the count wraps past 24 bits
		'{32'h8000_0000, 1'b0, 16'd0,     1'b1, 24'h3FFFFF, 1'b0},
		'{32'h7FFF_FFFF, 1'b0, 16'd0,     1'b1, 24'h3FFFFF, 1'b1},
		'{32'hFFFF_FFFF, 1'b0, 16'd0,     1'b1, 24'hA00000, 1'b0},
		// tiny forward move: positive code with a zero count
		'{32'h0000_0001, 1'b0, 16'd0,     1'b1, 24'h000000, 1'b1},
		'{32'h0000_8000, 1'b0, 16'd0,     1'b0, 24'h000000, 1'b0},
		// largest scale
		'{32'h8000_0000, 1'b1, 16'hFFFF,  1'b0, 24'h000000, 1'b0},
		'{32'h7FFF_FFFF, 1'b0, 16'd0,     1'b1, 24'hFEFFFF, 1'b1},
		// zero scale is taken and gives no pulses
		'{32'h8000_0000, 1'b1, 16'h0000,  1'b1, 24'h000000, 1'b0},
		'{32'h1234_5678, 1'b0, 16'd0,     1'b1, 24'h000000, 1'b1},
		// smallest nonzero scale
		'{32'h1235_5678, 1'b1, 16'h0001,  1'b1, 24'h000001, 1'b1},
		'{32'hFFFF_0000, 1'b0, 16'd0,     1'b0, 24'h000000, 1'b0},
		'{32'h5A5A_5A5A, 1'b1, PPM_RESET, 1'b0, 24'h000000, 1'b0},
		'{32'hA5A5_A5A5, 1'b0, 16'd0,     1'b0, 24'h000000, 1'b0},
		'{32'hA5A5_A5A5, 1'b0, 16'd0,     1'b1, 24'h000000, 1'b0}
	};

	// bytes still owed by the block, oldest first
	frame_byte_t frame_bytes_due [$];
	frame_byte_t seen_due;

	// predictor state, tracks the block's previous target and scale register
	logic [POS_W-1:0] held_target = '0;
	logic [PPM_W-1:0] ppm_now     = PPM_RESET;

	int mismatches    = 0;
	bit quiet         = 1'b0;
	bit long_hold_req = 1'b0;

	stepper_move_command_framer_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.target_position (target_position),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.tx_byte         (tx_byte),
		.guide_id        (guide_id),
		.last_byte       (last_byte),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// reset held low from the start, released once
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// pulse count and direction of a move, then the target becomes the held one
	task automatic predict_move(input logic [POS_W-1:0] target,
			output logic [PULSE_W-1:0] pulse, output logic up);
		logic signed [POS_W:0] move;
		logic [63:0]           mag;
		logic [63:0]           prod;
		move  = $signed({target[POS_W-1], target})
			- $signed({held_target[POS_W-1], held_target});
		mag   = {31'b0, (move[POS_W] ? -move : move)};
		prod  = mag * {48'b0, ppm_now};
		pulse = prod[FRAC_BITS +: PULSE_W];
		// a zero move counts as non-positive
		up    = !move[POS_W] && (move != '0);
		held_target = target;
	endtask

	// queue both frames of one move, guide 1 first
	task automatic queue_move_frames(input logic [PULSE_W-1:0] pulse, input logic up);
		logic [7:0]  f [FRAME_LEN];
		logic [7:0]  sum;
		logic        guide_up;
		frame_byte_t fb;
		int          g;
		int          i;
		for (g = 1; g <= NUM_GUIDES; g++) begin
			// guide 2 runs the other way round
			guide_up = (g == 1) ? up : !up;
			f[0] = SYNC0;
			f[1] = SYNC1;
			f[2] = PAD;
			f[3] = 8'(g);
			f[4] = guide_up ? DIR_UP : DIR_DOWN;
			f[5] = pulse[7:0];
			f[6] = pulse[15:8];
			f[7] = pulse[23:16];
			f[8] = PAD;
			sum  = '0;
			for (i = 0; i < FRAME_LEN - 1; i++)
				sum = sum + f[i];
			f[FRAME_LEN-1] = sum;
			for (i = 0; i < FRAME_LEN; i++) begin
				fb.value = f[i];
				fb.guide = GUIDE_W'(g);
				fb.last  = (g == NUM_GUIDES) && (i == FRAME_LEN - 1);
				frame_bytes_due.push_back(fb);
			end
		end
	endtask

	// offer a target and wait for its transfer; valid stays high afterwards
	task automatic offer_target(input logic [POS_W-1:0] target, input logic typed,
			input logic [PULSE_W-1:0] typed_pulse, input logic typed_up);
		logic [PULSE_W-1:0] pulse;
		logic               up;
		in_valid        <= 1'b1;
		target_position <= target;
		do @(posedge clk); while (in_stall);
		predict_move(target, pulse, up);
		if (typed)
			queue_move_frames(typed_pulse, typed_up);
		else
			queue_move_frames(pulse, up);
	endtask

	// random sender gap, none in the quiet tail
	task automatic maybe_pause_sender();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// stop offering until every owed byte is out, then let the pipeline settle
	task automatic drain_frames();
		in_valid <= 1'b0;
		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// scale write, only ever with the block idle
	task automatic write_ppm(input logic [PPM_W-1:0] ppm);
		drain_frames();
		cfg_valid <= 1'b1;
		cfg_data  <= ppm;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ppm_now = ppm;
	endtask

	// mostly moves near the held target, plus zero moves, extremes and wild jumps
	function automatic logic [POS_W-1:0] pick_target();
		logic [POS_W-1:0] target;
		int               sh;
		case ($urandom_range(0, 9))
			0: target = held_target;
			1: begin
				case ($urandom_range(0, 3))
					0:       target = 32'h7FFF_FFFF;
					1:       target = 32'h8000_0000;
					2:       target = '0;
					default: target = '1;
				endcase
			end
			2, 3: target = $urandom;
			default: begin
				sh     = $urandom_range(4, 30);
				target = held_target + 32'($signed($urandom) >>> sh);
			end
		endcase
		return target;
	endfunction

	// scale away from the extremes for the mid phase
	function automatic logic [PPM_W-1:0] PPM_WIDTH_RANDOM();
		return PPM_W'($urandom_range(2, 65534));
	endfunction

	// sender: directed table, then random phases each with its own scale
	initial begin
		move_row_t row;
		int        r;
		int        phase;
		int        n;
		while (arst_n !== 1'b1) @(posedge clk);
		@(posedge clk);
		for (r = 0; r < DIRECTED_ROWS; r++) begin
			row = directed_rows[r];
			if (row.set_ppm)
				write_ppm(row.new_ppm);
			offer_target(row.target, row.typed, row.pulse, row.up);
			maybe_pause_sender();
		end
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_ppm(16'hFFFF);
				1: write_ppm(16'h0001);
				2: write_ppm(16'h0000);
				3: write_ppm(PPM_WIDTH_RANDOM());
				4: write_ppm(PPM_RESET);
				default: begin
					write_ppm(16'($urandom_range(1, 65535)));
					// last stretch runs with no idling on either side
					quiet = 1'b1;
				end
			endcase
			// receiver holds off while back-to-back targets fill the block
			if (phase == 1)
				long_hold_req = 1'b1;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				offer_target(pick_target(), 1'b0, '0, 1'b0);
				if (phase == 1 && n == 30)
					drain_frames();
				else if (!(phase == 1 && n < 16))
					maybe_pause_sender();
			end
		end
		in_valid <= 1'b0;
		while (frame_bytes_due.size() != 0) @(posedge clk);
		// any stray transfer after the last byte shows up here
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// receiver: random stall bursts, one long hold on request, none in the tail
	initial begin
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				@(posedge clk);
			end
		end
	end

	// every output transfer against the oldest owed byte
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (frame_bytes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected transfer: byte %h guide %0d last %b",
						tx_byte, guide_id, last_byte);
			end else begin
				seen_due = frame_bytes_due.pop_front();
				if (tx_byte !== seen_due.value || guide_id !== seen_due.guide
						|| last_byte !== seen_due.last) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("byte mismatch: expected %h/%0d/%b, got %h/%0d/%b",
							seen_due.value, seen_due.guide, seen_due.last,
							tx_byte, guide_id, last_byte);
				end
			end
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
